FILE: rtl/mbd_pkg.sv
// ----------------------------------------------------------------------------
// mbd_pkg
// Shared constants and types for the 2x2 box-filter mipmap downsampler.
// ----------------------------------------------------------------------------
`default_nettype none

package mbd_pkg;

    // Width of the line_width configuration register.
    localparam int LW_BITS = 12;
    // line_width after reset.
    localparam int LINE_WIDTH_RESET = 2048;

    // Defaults for the top-level parameters.
    localparam int MAX_WIDTH_DEF    = 2048;
    localparam int CHANNEL_BITS_DEF = 8;

    // Per-lane strobes issued by the column controller for an accepted pixel.
    typedef struct packed {
        logic load_left;   // even column: hold pixel as the left half of the pair
        logic write_pair;  // odd column, even row: store the pair sum
        logic read_pair;   // odd column, odd row: fetch the stored pair sum
    } t_lane_ctl;

    // Status of the pixel travelling through the store read stage.
    typedef struct packed {
        logic valid;       // an output pixel is formed from this stage
        logic row_end;     // last output pixel of the row
    } t_s1;

endpackage : mbd_pkg

`default_nettype wire

FILE: rtl/mbd_ctrl.sv
// ----------------------------------------------------------------------------
// mbd_ctrl
// Column and row tracking, width register and pipeline enable.
// ----------------------------------------------------------------------------
`default_nettype none

module mbd_ctrl #(
    parameter int MAX_WIDTH = mbd_pkg::MAX_WIDTH_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_valid,
    input  wire [mbd_pkg::LW_BITS-1:0]   i_cfg_data,
    input  wire                          i_in_valid,
    input  wire                          i_start_of_frame,
    input  wire                          i_out_stall,
    input  wire                          i_out_valid,
    output logic                         o_in_stall,
    output logic                         o_en,
    output mbd_pkg::t_lane_ctl           o_ctl,
    output logic [$clog2(MAX_WIDTH/2)-1:0] o_idx,
    output mbd_pkg::t_s1                 o_s1
);
    import mbd_pkg::*;

    localparam int CW        = $clog2(MAX_WIDTH);
    localparam int IB        = $clog2(MAX_WIDTH / 2);
    localparam int MW_BITS   = $clog2(MAX_WIDTH + 1);
    localparam int EW        = (MW_BITS > LW_BITS) ? MW_BITS : LW_BITS;
    localparam int MaxEven   = (MAX_WIDTH / 2) * 2;
    localparam int ResetEven = (LINE_WIDTH_RESET < MaxEven) ? LINE_WIDTH_RESET : MaxEven;

    logic [EW-1:0] r_last_col;
    logic [EW-1:0] n_last_col;
    logic [CW-1:0] r_col;
    logic [CW-1:0] n_col;
    logic          r_odd;
    logic          n_odd;
    t_s1           r_s1;
    t_s1           n_s1;

    logic [EW-1:0] even_w;
    logic [CW-1:0] col_eff;
    logic          odd_eff;
    logic          accept;
    logic          row_last;

    // Effective width minus one, settled when the register is written.
    always_comb begin
        even_w = EW'({i_cfg_data[LW_BITS-1:1], 1'b0});
        if (even_w < EW'(2)) begin
            even_w = EW'(2);
        end else if (even_w > EW'(MaxEven)) begin
            even_w = EW'(MaxEven);
        end
        n_last_col = even_w - EW'(1);
    end

    // Advance unless the output register holds a pixel that is not taken.
    assign o_en       = !(i_out_valid && i_out_stall);
    assign o_in_stall = !o_en;
    assign accept     = i_in_valid && o_en;

    // Start of frame clears position before the pixel is taken.
    assign col_eff  = i_start_of_frame ? '0 : r_col;
    assign odd_eff  = i_start_of_frame ? 1'b0 : r_odd;
    assign row_last = EW'(col_eff) >= r_last_col;
    assign o_idx    = IB'(col_eff >> 1);

    always_comb begin
        o_ctl.load_left  = accept && !col_eff[0];
        o_ctl.write_pair = accept && col_eff[0] && !odd_eff;
        o_ctl.read_pair  = accept && col_eff[0] && odd_eff;
    end

    always_comb begin
        n_col = r_col;
        n_odd = r_odd;
        n_s1  = r_s1;
        if (accept) begin
            if (row_last) begin
                n_col = '0;
                n_odd = !odd_eff;
            end else begin
                n_col = col_eff + CW'(1);
                n_odd = odd_eff;
            end
        end
        if (o_en) begin
            n_s1.valid   = o_ctl.read_pair;
            n_s1.row_end = row_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_col <= EW'(ResetEven - 1);
            r_col      <= '0;
            r_odd      <= 1'b0;
            r_s1       <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_last_col <= n_last_col;
            end
            r_col <= n_col;
            r_odd <= n_odd;
            r_s1  <= n_s1;
        end
    end

    assign o_s1 = r_s1;

endmodule : mbd_ctrl

`default_nettype wire

FILE: rtl/mbd_lane.sv
// ----------------------------------------------------------------------------
// mbd_lane
// One color channel: horizontal pair sum, line store and 2x2 average.
// ----------------------------------------------------------------------------
`default_nettype none

module mbd_lane #(
    parameter int MAX_WIDTH    = mbd_pkg::MAX_WIDTH_DEF,
    parameter int CHANNEL_BITS = mbd_pkg::CHANNEL_BITS_DEF
) (
    input  wire                            i_clk,
    input  wire                            i_en,
    input  mbd_pkg::t_lane_ctl             i_ctl,
    input  wire [$clog2(MAX_WIDTH/2)-1:0]  i_idx,
    input  wire [CHANNEL_BITS-1:0]         i_px,
    output logic [CHANNEL_BITS-1:0]        o_avg
);
    import mbd_pkg::*;

    localparam int Depth = MAX_WIDTH / 2;
    localparam int PW    = CHANNEL_BITS + 1;

    logic [CHANNEL_BITS-1:0] r_left;
    logic [PW-1:0]           r_pair;
    logic [PW-1:0]           r_rd_q;
    logic [PW-1:0]           mem [Depth];
    logic [PW-1:0]           pair;
    logic [PW:0]             quad;

    assign pair = PW'(r_left) + PW'(i_px);

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_left) begin
            r_left <= i_px;
        end
        if (i_ctl.write_pair) begin
            mem[i_idx] <= pair;
        end
        if (i_en) begin
            r_rd_q <= mem[i_idx];
            r_pair <= pair;
        end
    end

    // Sum of four pixels, drop the two low bits.
    assign quad  = (PW + 1)'(r_rd_q) + (PW + 1)'(r_pair);
    assign o_avg = quad[PW:2];

endmodule : mbd_lane

`default_nettype wire

FILE: rtl/mbd_merge.sv
// ----------------------------------------------------------------------------
// mbd_merge
// Output register joining the four lane averages and the row end flag.
// ----------------------------------------------------------------------------
`default_nettype none

module mbd_merge #(
    parameter int CHANNEL_BITS = mbd_pkg::CHANNEL_BITS_DEF
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_en,
    input  mbd_pkg::t_s1             i_s1,
    input  wire [CHANNEL_BITS-1:0]   i_red,
    input  wire [CHANNEL_BITS-1:0]   i_green,
    input  wire [CHANNEL_BITS-1:0]   i_blue,
    input  wire [CHANNEL_BITS-1:0]   i_alpha,
    output logic                     o_valid,
    output logic [CHANNEL_BITS-1:0]  o_red,
    output logic [CHANNEL_BITS-1:0]  o_green,
    output logic [CHANNEL_BITS-1:0]  o_blue,
    output logic [CHANNEL_BITS-1:0]  o_alpha,
    output logic                     o_row_end
);
    import mbd_pkg::*;

    logic                    r_valid;
    logic                    r_row_end;
    logic [CHANNEL_BITS-1:0] r_red;
    logic [CHANNEL_BITS-1:0] r_green;
    logic [CHANNEL_BITS-1:0] r_blue;
    logic [CHANNEL_BITS-1:0] r_alpha;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_s1.valid;
        end
    end

    // Load payload only with a new pixel; hold it while stalled.
    always_ff @(posedge i_clk) begin
        if (i_en && i_s1.valid) begin
            r_row_end <= i_s1.row_end;
            r_red     <= i_red;
            r_green   <= i_green;
            r_blue    <= i_blue;
            r_alpha   <= i_alpha;
        end
    end

    assign o_valid   = r_valid;
    assign o_row_end = r_row_end;
    assign o_red     = r_red;
    assign o_green   = r_green;
    assign o_blue    = r_blue;
    assign o_alpha   = r_alpha;

endmodule : mbd_merge

`default_nettype wire

FILE: rtl/mipmap_box_downsample_2x2_unit.sv
// ----------------------------------------------------------------------------
// mipmap_box_downsample_2x2_unit
// 2x2 box-filter mipmap reduction of a raster RGBA pixel stream.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Handshake                  | Payload
//  ---------+-----------+----------------------------+-----------------------------
//  cfg      | in        | i_cfg_valid / o_cfg_ready  | i_cfg_data (line_width)
//  in       | in        | i_in_valid / o_in_stall    | start_of_frame, RGBA in
//  out      | out       | o_out_valid / i_out_stall  | RGBA out, row_end
//
//  One source pixel is transferred per clock when the output side keeps up.
//  The source pixel that completes a 2x2 block passes the line store read
//  stage and then the output register before its output pixel appears.
//  Each lane holds its own line store of pair sums.
//  Reset is synchronous, active low; it clears position, width (2048) and
//  valids. The line store is not cleared: an even row fills it before use.
//  A stall while an output pixel is held freezes the whole pipe and stalls
//  the input.
//
// ----------------------------------------------------------------------------
`default_nettype none

module mipmap_box_downsample_2x2_unit #(
    parameter int MAX_WIDTH    = mbd_pkg::MAX_WIDTH_DEF,
    parameter int CHANNEL_BITS = mbd_pkg::CHANNEL_BITS_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    // configuration write
    input  wire                          i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire [mbd_pkg::LW_BITS-1:0]   i_cfg_data,
    // source pixels
    input  wire                          i_in_valid,
    output logic                         o_in_stall,
    input  wire                          i_start_of_frame,
    input  wire [CHANNEL_BITS-1:0]       i_red_in,
    input  wire [CHANNEL_BITS-1:0]       i_green_in,
    input  wire [CHANNEL_BITS-1:0]       i_blue_in,
    input  wire [CHANNEL_BITS-1:0]       i_alpha_in,
    // downsampled pixels
    output logic                         o_out_valid,
    input  wire                          i_out_stall,
    output logic [CHANNEL_BITS-1:0]      o_red_out,
    output logic [CHANNEL_BITS-1:0]      o_green_out,
    output logic [CHANNEL_BITS-1:0]      o_blue_out,
    output logic [CHANNEL_BITS-1:0]      o_alpha_out,
    output logic                         o_row_end
);
    import mbd_pkg::*;

    localparam int IB = $clog2(MAX_WIDTH / 2);

    logic          en;
    t_lane_ctl     lane_ctl;
    t_s1           s1;
    logic [IB-1:0] idx;

    logic [CHANNEL_BITS-1:0] avg_red;
    logic [CHANNEL_BITS-1:0] avg_green;
    logic [CHANNEL_BITS-1:0] avg_blue;
    logic [CHANNEL_BITS-1:0] avg_alpha;

    // Always ready; the user must write the width only when idle (not enforced).
    assign o_cfg_ready = 1'b1;

    // Column / row tracking and the shared pipeline enable.
    mbd_ctrl #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .i_start_of_frame (i_start_of_frame),
        .i_out_stall      (i_out_stall),
        .i_out_valid      (o_out_valid),
        .o_in_stall       (o_in_stall),
        .o_en             (en),
        .o_ctl            (lane_ctl),
        .o_idx            (idx),
        .o_s1             (s1)
    );

    // One lane per color channel, all driven by the same strobes.
    mbd_lane #(
        .MAX_WIDTH    (MAX_WIDTH),
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_lane_red (
        .i_clk (i_clk),
        .i_en  (en),
        .i_ctl (lane_ctl),
        .i_idx (idx),
        .i_px  (i_red_in),
        .o_avg (avg_red)
    );

    mbd_lane #(
        .MAX_WIDTH    (MAX_WIDTH),
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_lane_green (
        .i_clk (i_clk),
        .i_en  (en),
        .i_ctl (lane_ctl),
        .i_idx (idx),
        .i_px  (i_green_in),
        .o_avg (avg_green)
    );

    mbd_lane #(
        .MAX_WIDTH    (MAX_WIDTH),
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_lane_blue (
        .i_clk (i_clk),
        .i_en  (en),
        .i_ctl (lane_ctl),
        .i_idx (idx),
        .i_px  (i_blue_in),
        .o_avg (avg_blue)
    );

    mbd_lane #(
        .MAX_WIDTH    (MAX_WIDTH),
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_lane_alpha (
        .i_clk (i_clk),
        .i_en  (en),
        .i_ctl (lane_ctl),
        .i_idx (idx),
        .i_px  (i_alpha_in),
        .o_avg (avg_alpha)
    );

    // Join the lanes into one output pixel; hold it until transferred.
    mbd_merge #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_merge (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_s1      (s1),
        .i_red     (avg_red),
        .i_green   (avg_green),
        .i_blue    (avg_blue),
        .i_alpha   (avg_alpha),
        .o_valid   (o_out_valid),
        .o_red     (o_red_out),
        .o_green   (o_green_out),
        .o_blue    (o_blue_out),
        .o_alpha   (o_alpha_out),
        .o_row_end (o_row_end)
    );

endmodule : mipmap_box_downsample_2x2_unit

`default_nettype wire

FILE: tb/mipmap_downsample_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mipmap_downsample_checker
// Watches the configuration, source and output channels of the 2x2 mipmap
// downsampler. It keeps its own copy of the line width, column position and
// line of pair sums, predicts every averaged pixel and compares each output
// transfer field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module mipmap_downsample_checker #(
    parameter int MAX_WIDTH    = mbd_pkg::MAX_WIDTH_DEF,
    parameter int CHANNEL_BITS = mbd_pkg::CHANNEL_BITS_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_valid,
    input  wire                          i_cfg_ready,
    input  wire [mbd_pkg::LW_BITS-1:0]   i_cfg_data,
    input  wire                          i_in_valid,
    input  wire                          i_in_stall,
    input  wire                          i_start_of_frame,
    input  wire [CHANNEL_BITS-1:0]       i_red_in,
    input  wire [CHANNEL_BITS-1:0]       i_green_in,
    input  wire [CHANNEL_BITS-1:0]       i_blue_in,
    input  wire [CHANNEL_BITS-1:0]       i_alpha_in,
    input  wire                          i_out_valid,
    input  wire                          i_out_stall,
    input  wire [CHANNEL_BITS-1:0]       i_red_out,
    input  wire [CHANNEL_BITS-1:0]       i_green_out,
    input  wire [CHANNEL_BITS-1:0]       i_blue_out,
    input  wire [CHANNEL_BITS-1:0]       i_alpha_out,
    input  wire                          i_row_end,
    output int                           o_failures,
    output int                           o_pending,
    output int                           o_checked
);

    localparam int PAIRS = MAX_WIDTH / 2;

    typedef logic [CHANNEL_BITS-1:0] t_chan;
    typedef logic [CHANNEL_BITS:0]   t_pair;

    typedef struct packed {
        t_chan red;
        t_chan green;
        t_chan blue;
        t_chan alpha;
        logic  row_end;
    } t_mip_px;

    logic [mbd_pkg::LW_BITS-1:0] line_width;
    int                          column;
    logic                        odd_row;
    t_chan                       left_px [4];
    t_pair                       pair_line [PAIRS][4];
    t_mip_px                     mip_expected [$];

    // Advance the model by one source pixel; queue an averaged pixel when the
    // pixel closes a 2x2 block on an odd row.
    task automatic predict_downsample(input logic sof, input t_chan px [4]);
        int                      w;
        int                      slot;
        t_pair                   pair [4];
        logic [CHANNEL_BITS+1:0] quad;
        t_mip_px                 avg;
        t_chan                   ch [4];
        w = int'(line_width) & ~1;
        if (w < 2) w = 2;
        if (w > MAX_WIDTH) w = MAX_WIDTH & ~1;
        if (sof) begin
            column  = 0;
            odd_row = 1'b0;
        end
        if (column % 2 == 0) begin
            left_px = px;
        end else begin
            slot = (column / 2) % PAIRS;
            for (int k = 0; k < 4; k++) pair[k] = left_px[k] + px[k];
            if (!odd_row) begin
                pair_line[slot] = pair;
            end else begin
                for (int k = 0; k < 4; k++) begin
                    quad  = pair_line[slot][k] + pair[k];
                    ch[k] = quad[CHANNEL_BITS+1:2];
                end
                avg.red     = ch[0];
                avg.green   = ch[1];
                avg.blue    = ch[2];
                avg.alpha   = ch[3];
                avg.row_end = (column + 1 >= w);
                mip_expected.push_back(avg);
            end
        end
        column++;
        if (column >= w) begin
            column  = 0;
            odd_row = ~odd_row;
        end
    endtask

    task automatic check_field(input string field, input int want, input int got);
        if (want != got) begin
            o_failures++;
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_chan   px [4];
        t_mip_px want;
        if (!i_rst_n) begin
            line_width = mbd_pkg::LINE_WIDTH_RESET;
            column     = 0;
            odd_row    = 1'b0;
            for (int k = 0; k < 4; k++) left_px[k] = '0;
            mip_expected.delete();
            o_failures = 0;
            o_checked  = 0;
        end else begin
            // Output first: a prediction made at this edge cannot be due yet.
            if (i_out_valid && !i_out_stall) begin
                o_checked++;
                if (mip_expected.size() == 0) begin
                    o_failures++;
                    $display("%0t ns: unexpected output, expected none, got %0d %0d %0d %0d end %0b",
                             $time, i_red_out, i_green_out, i_blue_out, i_alpha_out,
                             i_row_end);
                end else begin
                    want = mip_expected.pop_front();
                    check_field("red", want.red, i_red_out);
                    check_field("green", want.green, i_green_out);
                    check_field("blue", want.blue, i_blue_out);
                    check_field("alpha", want.alpha, i_alpha_out);
                    check_field("row_end", want.row_end, i_row_end);
                end
            end
            if (i_cfg_valid && i_cfg_ready) line_width = i_cfg_data;
            if (i_in_valid && !i_in_stall) begin
                px[0] = i_red_in;
                px[1] = i_green_in;
                px[2] = i_blue_in;
                px[3] = i_alpha_in;
                predict_downsample(i_start_of_frame, px);
            end
        end
        o_pending <= mip_expected.size();
    end

endmodule

FILE: tb/mipmap_box_downsample_2x2_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mipmap_box_downsample_2x2_unit_test
// Drives raster RGBA frames of many line widths into the 2x2 downsampler,
// with random idling on both channels, and lets the checker beside the block
// predict and compare every averaged pixel.
// ----------------------------------------------------------------------------
module mipmap_box_downsample_2x2_unit_test;

    localparam int CB           = mbd_pkg::CHANNEL_BITS_DEF;
    localparam int MAX_W        = mbd_pkg::MAX_WIDTH_DEF;
    localparam int LWB          = mbd_pkg::LW_BITS;
    // Leave generous slack for flushing the pipe.
    localparam int DRAIN_CYCLES = 8;
    // Source pixels to send in each of the three idling phases.
    localparam int PHASE_PIXELS = 275;
    // Pixels sent under the widest width setting.
    localparam int WIDE_PIXELS  = 16;

    logic            clk       = 1'b0;
    logic            rst_n     = 1'b0;
    logic            cfg_valid = 1'b0;
    logic [LWB-1:0]  cfg_data  = '0;
    logic            in_valid  = 1'b0;
    logic            sof       = 1'b0;
    logic [CB-1:0]   red       = '0;
    logic [CB-1:0]   green     = '0;
    logic [CB-1:0]   blue      = '0;
    logic [CB-1:0]   alpha     = '0;
    logic            out_stall = 1'b0;

    wire             cfg_ready;
    wire             in_stall;
    wire             out_valid;
    wire [CB-1:0]    red_out;
    wire [CB-1:0]    green_out;
    wire [CB-1:0]    blue_out;
    wire [CB-1:0]    alpha_out;
    wire             row_end;

    int              failures;
    int              pending;
    int              checked;

    // Idle percentages for sender and receiver; quiet forces the receiver to
    // take every output so the pipe flushes before a register write.
    int              tx_idle_pct  = 0;
    int              rx_idle_pct  = 0;
    logic            quiet        = 1'b0;
    int              pixels_sent  = 0;
    int              widths_used  = 0;

    mipmap_box_downsample_2x2_unit i_dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (cfg_ready),
        .i_cfg_data       (cfg_data),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_start_of_frame (sof),
        .i_red_in         (red),
        .i_green_in       (green),
        .i_blue_in        (blue),
        .i_alpha_in       (alpha),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_red_out        (red_out),
        .o_green_out      (green_out),
        .o_blue_out       (blue_out),
        .o_alpha_out      (alpha_out),
        .o_row_end        (row_end)
    );

    mipmap_downsample_checker i_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_valid      (cfg_valid),
        .i_cfg_ready      (cfg_ready),
        .i_cfg_data       (cfg_data),
        .i_in_valid       (in_valid),
        .i_in_stall       (in_stall),
        .i_start_of_frame (sof),
        .i_red_in         (red),
        .i_green_in       (green),
        .i_blue_in        (blue),
        .i_alpha_in       (alpha),
        .i_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .i_red_out        (red_out),
        .i_green_out      (green_out),
        .i_blue_out       (blue_out),
        .i_alpha_out      (alpha_out),
        .i_row_end        (row_end),
        .o_failures       (failures),
        .o_pending        (pending),
        .o_checked        (checked)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin
        #3_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Receiver back-pressure: a fresh draw every cycle, none while flushing.
    always @(posedge clk) begin
        out_stall <= !quiet && ($urandom_range(99) < rx_idle_pct);
    end

    // Mostly random channel values, with the extremes weighted up.
    function automatic logic [CB-1:0] rand_chan();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return CB'($urandom);
        endcase
    endfunction

    // Offer one pixel and hold it until the transfer. Valid is left high on
    // return so back-to-back pixels never drop it within a time step.
    task automatic send_pixel(input logic first, input logic [CB-1:0] r,
                              input logic [CB-1:0] g, input logic [CB-1:0] b,
                              input logic [CB-1:0] a);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        sof      <= first;
        red      <= r;
        green    <= g;
        blue     <= b;
        alpha    <= a;
        do @(posedge clk); while (in_stall);
        pixels_sent++;
    endtask

    task automatic send_random_pixel(input logic first);
        send_pixel(first, rand_chan(), rand_chan(), rand_chan(), rand_chan());
    endtask

    // Drop valid and wait for every predicted pixel to come out. The pending
    // count is registered, so always advance at least once before looking.
    task automatic hold_until_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // Flush the pipe with the receiver open, then write line_width.
    task automatic reprogram(input logic [LWB-1:0] value);
        hold_until_drained();
        quiet <= 1'b1;
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        quiet     <= 1'b0;
        widths_used++;
    endtask

    // One frame of random pixels; cut_at >= 0 truncates it after that many
    // transfers. Occasionally pause mid-frame until the output side drains.
    task automatic send_frame(input int row_len, input int rows, input logic with_sof,
                              input int cut_at);
        for (int n = 0; n < row_len * rows && n != cut_at; n++) begin
            if (n > 0 && $urandom_range(199) == 0) hold_until_drained();
            send_random_pixel(with_sof && n == 0);
        end
    endtask

    initial begin : stimulus
        int   row_len;
        int   rows;
        int   cut;
        int   target;
        int   pick;
        logic need_sof;
        logic [LWB-1:0] value;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset width, no start-of-frame: the first pixel is column 0 of an
        // even row anyway. Pairs are all-max, all-zero, then random.
        send_pixel(1'b0, '1, '1, '1, '1);
        send_pixel(1'b0, '1, '1, '1, '1);
        send_pixel(1'b0, '0, '0, '0, '0);
        send_pixel(1'b0, '0, '0, '0, '0);
        send_random_pixel(1'b0);
        send_random_pixel(1'b0);
        // Shrink the width mid-row: column 6 already passes width 4, so the
        // next pixel ends the row and the odd row reuses the first two pairs.
        reprogram(LWB'(4));
        send_random_pixel(1'b0);
        send_pixel(1'b0, '1, '1, '1, '1);
        send_pixel(1'b0, '1, '1, '1, '1);
        send_pixel(1'b0, '0, '0, '0, '0);
        send_pixel(1'b0, '0, '0, '0, '0);

        // Width 0 rounds up to 2; one block whose sums truncate on the shift.
        reprogram(LWB'(0));
        send_pixel(1'b1, CB'(1), '1, CB'(128), CB'(0));
        send_pixel(1'b0, CB'(1), '1, CB'(127), CB'(0));
        send_pixel(1'b0, CB'(1), '1, CB'(128), CB'(0));
        send_pixel(1'b0, CB'(0), CB'(254), CB'(128), CB'(3));

        // Start of frame in the middle of a row restarts at column 0.
        reprogram(LWB'(4));
        send_random_pixel(1'b1);
        send_random_pixel(1'b0);
        send_frame(4, 2, 1'b1, -1);

        // Random frames in three idling phases. Width changes always come
        // with a start of frame, so the odd row only reads freshly written
        // pairs; shrinking or growing are both safe then.
        row_len  = 4;
        need_sof = 1'b1;
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    tx_idle_pct = 30;
                    rx_idle_pct <= 63;
                end
                1: begin
                    tx_idle_pct = 63;
                    rx_idle_pct <= 30;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct <= 0;
                end
            endcase
            // Open each phase on an odd or minimal width setting.
            value    = LWB'(3 - phase);
            reprogram(value);
            row_len  = 2;
            need_sof = 1'b1;
            target   = pixels_sent + PHASE_PIXELS;
            while (pixels_sent < target) begin
                if ($urandom_range(99) < 40) begin
                    pick = $urandom_range(9);
                    if (pick < 4) begin
                        value   = LWB'(pick);
                        row_len = 2;
                    end else begin
                        row_len = 2 * $urandom_range(2, 20);
                        // An odd setting rounds down to the same row length.
                        value   = LWB'(row_len + $urandom_range(1));
                    end
                    reprogram(value);
                    need_sof = 1'b1;
                end
                rows = 2 * $urandom_range(1, 3);
                cut  = ($urandom_range(99) < 15) ? $urandom_range(1, row_len * rows - 1) : -1;
                send_frame(row_len, rows, need_sof || $urandom_range(1), cut);
                // A truncated frame leaves the position mid-row: restart next.
                need_sof = (cut >= 0);
            end
        end

        // Widest setting: a short stretch of an even row under it.
        reprogram('1);
        send_frame(MAX_W, 2, 1'b1, WIDE_PIXELS);

        hold_until_drained();
        quiet <= 1'b1;
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d source pixels over %0d line width writes, from 0 to %0d,",
                 pixels_sent, widths_used, (1 << LWB) - 1);
        $display("and compared %0d averaged pixels under three back-pressure mixes.", checked);
        if (failures == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
